### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, reset by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every edge outside reset.
`define MGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MGR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mgr_pkg.sv
// ----------------------------------------------------------------------------
// mgr_pkg
// Constants, codes and types of the minority game round engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mgr_pkg;

    localparam int MAX_PLAYERS = 128;
    localparam int PLAYER_W    = 7;                 // player index width
    localparam int MAX_MEMORY  = 8;                 // history width
    localparam int STRAT_AW    = PLAYER_W + MAX_MEMORY;
    localparam int SCORE_W     = 32;
    localparam int CNT_W       = 8;                 // holds 0..MAX_PLAYERS
    localparam int PCNT_W      = 8;
    localparam int MLEN_W      = 4;
    localparam int CFG_W       = 8;

    localparam logic [MAX_MEMORY-1:0] HIST_RESET = MAX_MEMORY'(2);
    localparam logic [PCNT_W-1:0]     PCNT_RESET = PCNT_W'(101);
    localparam logic [MLEN_W-1:0]     MLEN_RESET = MLEN_W'(2);
    localparam logic [MLEN_W-1:0]     MLEN_MIN   = MLEN_W'(2);
    localparam logic [MLEN_W-1:0]     MLEN_MAX   = MLEN_W'(MAX_MEMORY);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ROUND = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_PLAYER_COUNT  = 1'b0,
        REG_MEMORY_LENGTH = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_VOTE   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    // one memory row holds both scores of a player
    typedef struct packed {
        logic [SCORE_W-1:0] s1;
        logic [SCORE_W-1:0] s0;
    } t_score_row;

    function automatic logic [SCORE_W-1:0] sat_inc(input logic [SCORE_W-1:0] v);
        sat_inc = (&v) ? v : v + SCORE_W'(1);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/minority_game_round.sv
// ----------------------------------------------------------------------------
// minority_game_round
// Minority game engine: strategy bit loads, score clear and one round per
// command, with scores and strategies held in synchronous memories.
// ----------------------------------------------------------------------------
// Load and clear transfers leave tready high, so they go back to back.
// A round runs a vote pass and then a read-modify-write score pass, each through
// the single memory read port, then registers its result. tready stays low until
// the round is back in IDLE; a result still waiting holds the next one in DONE.
// Reset (synchronous, active low) zeroes all scores via per-row valid bits,
// restores history 2, player_count 101, memory_length 2; strategies stay unset.
`default_nettype none

module minority_game_round (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [6:0] player, [7] which_strategy, [15:8] history_index,
    // [16] strategy_bit, [23:17] zero
    input  wire logic [23:0] i_s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  i_s_axis_tuser,
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] ones_count, [8] minority_side, [16:9] minority_size,
    // [24:17] new_history, [31:25] zero
    output logic [31:0]      o_m_axis_tdata,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata
);

    localparam int PW = mgr_pkg::PLAYER_W;
    localparam int HW = mgr_pkg::MAX_MEMORY;
    localparam int CW = mgr_pkg::CNT_W;

    // ------------------------------------------------------------------
    // Memories: strategy bits per (player, pattern), scores per player.
    // ------------------------------------------------------------------
    logic [1:0]            mem_strat [2**mgr_pkg::STRAT_AW];
    mgr_pkg::t_score_row   mem_score [mgr_pkg::MAX_PLAYERS];

    // control state
    mgr_pkg::t_state       r_state;
    logic [CW-1:0]         r_idx;       // next row to read
    logic                  r_rd_vld;    // read data valid this cycle
    logic [PW-1:0]         r_rd_row;    // row of that data
    logic [CW-1:0]         r_ones;
    logic [CW-1:0]         r_zeros;
    logic [HW-1:0]         r_hist;
    logic [mgr_pkg::PCNT_W-1:0] r_pcount;
    logic [mgr_pkg::MLEN_W-1:0] r_mlen;
    logic [mgr_pkg::MAX_PLAYERS-1:0] r_row_vld;  // score row written since clear
    logic                  r_out_valid;

    // read data
    logic [1:0]            r_strat_q;
    mgr_pkg::t_score_row   r_score_q;
    logic                  r_vld_q;

    // result payload
    logic [CW-1:0]         r_out_ones;
    logic                  r_out_min;
    logic [CW-1:0]         r_out_small;
    logic [HW-1:0]         r_out_hist;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                  w_in_xfer;
    mgr_pkg::t_cmd         w_cmd;
    logic [PW-1:0]         w_ld_player;
    logic                  w_ld_which;
    logic [HW-1:0]         w_ld_pat;
    logic                  w_ld_bit;
    logic                  w_ld_we;
    logic [mgr_pkg::STRAT_AW-1:0] w_ld_addr;

    assign o_s_axis_tready = (r_state == mgr_pkg::ST_IDLE);
    assign w_in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd       = mgr_pkg::t_cmd'(i_s_axis_tuser);
    assign w_ld_player = i_s_axis_tdata[PW-1:0];
    assign w_ld_which  = i_s_axis_tdata[7];
    assign w_ld_pat    = i_s_axis_tdata[15:8];
    assign w_ld_bit    = i_s_axis_tdata[16];
    // player field is 7 bits, always inside the store
    assign w_ld_we     = w_in_xfer && (w_cmd == mgr_pkg::CMD_LOAD);
    assign w_ld_addr   = {w_ld_player, w_ld_pat};

    // ------------------------------------------------------------------
    // Round datapath
    // ------------------------------------------------------------------
    logic [CW-1:0]         w_n;         // clamped player count
    logic [mgr_pkg::MLEN_W-1:0] w_m;    // clamped memory length
    logic                  w_in_pass;
    logic                  w_rd_en;
    logic [PW-1:0]         w_rd_row;
    mgr_pkg::t_score_row   w_score;
    logic                  w_pick;
    logic                  w_vote;
    logic                  w_min;
    logic [CW-1:0]         w_small;
    mgr_pkg::t_score_row   w_new_row;
    logic                  w_sc_we;
    logic [HW:0]           w_hist_sum;
    logic [HW-1:0]         w_new_hist;
    logic                  w_done;
    logic [CW:0]           w_votes;

    assign w_n = (r_pcount > CW'(mgr_pkg::MAX_PLAYERS)) ? CW'(mgr_pkg::MAX_PLAYERS)
                                                         : r_pcount;
    always_comb begin
        w_m = r_mlen;
        if (r_mlen < mgr_pkg::MLEN_MIN) begin
            w_m = mgr_pkg::MLEN_MIN;
        end else if (r_mlen > mgr_pkg::MLEN_MAX) begin
            w_m = mgr_pkg::MLEN_MAX;
        end
    end

    assign w_in_pass = (r_state == mgr_pkg::ST_VOTE) || (r_state == mgr_pkg::ST_UPDATE);
    assign w_rd_en   = w_in_pass && (r_idx < w_n);
    assign w_rd_row  = r_idx[PW-1:0];
    assign w_done    = (r_state == mgr_pkg::ST_DONE);
    assign w_votes   = {1'b0, r_ones} + {1'b0, r_zeros};

    // rows never written since the last clear read as zero
    assign w_score = r_vld_q ? r_score_q : '0;
    assign w_pick  = !(w_score.s0 >= w_score.s1);
    assign w_vote  = r_strat_q[w_pick];

    // minority is 1 on a tie
    assign w_min   = (r_zeros >= r_ones);
    assign w_small = w_min ? r_ones : r_zeros;

    always_comb begin
        w_new_row    = w_score;
        if (r_strat_q[0] == w_min) begin
            w_new_row.s0 = mgr_pkg::sat_inc(w_score.s0);
        end
        if (r_strat_q[1] == w_min) begin
            w_new_row.s1 = mgr_pkg::sat_inc(w_score.s1);
        end
    end
    assign w_sc_we = (r_state == mgr_pkg::ST_UPDATE) && r_rd_vld;

    // shifted history; the sum may carry when bits sit above m
    assign w_hist_sum = {1'b0, (r_hist >> 1)}
                      + ((HW+1)'(w_min) << (w_m - mgr_pkg::MLEN_W'(1)));
    assign w_new_hist = w_hist_sum[HW-1:0];

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_ld_we && !w_ld_which) begin
            mem_strat[w_ld_addr][0] <= w_ld_bit;
        end
        if (w_ld_we && w_ld_which) begin
            mem_strat[w_ld_addr][1] <= w_ld_bit;
        end
        if (w_rd_en) begin
            r_strat_q <= mem_strat[{w_rd_row, r_hist}];
        end
    end

    // rows go strictly upward, so the write-back row never matches the row read
    always_ff @(posedge i_clk) begin
        if (w_sc_we) begin
            mem_score[r_rd_row] <= w_new_row;
        end
        if (w_rd_en) begin
            r_score_q <= mem_score[w_rd_row];
            r_vld_q   <= r_row_vld[w_rd_row];
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mgr_pkg::ST_IDLE;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_row    <= '0;
            r_ones      <= '0;
            r_zeros     <= '0;
            r_hist      <= mgr_pkg::HIST_RESET;
            r_pcount    <= mgr_pkg::PCNT_RESET;
            r_mlen      <= mgr_pkg::MLEN_RESET;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (mgr_pkg::t_reg'(i_cfg_addr))
                    mgr_pkg::REG_PLAYER_COUNT:  r_pcount <= i_cfg_wdata;
                    mgr_pkg::REG_MEMORY_LENGTH: r_mlen   <= i_cfg_wdata[mgr_pkg::MLEN_W-1:0];
                endcase
            end

            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_sc_we) begin
                r_row_vld[r_rd_row] <= 1'b1;
            end

            unique case (r_state)
                mgr_pkg::ST_IDLE: begin
                    if (w_in_xfer && (w_cmd == mgr_pkg::CMD_CLEAR)) begin
                        r_row_vld <= '0;
                    end
                    if (w_in_xfer && (w_cmd == mgr_pkg::CMD_ROUND)) begin
                        r_ones   <= '0;
                        r_zeros  <= '0;
                        r_idx    <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= mgr_pkg::ST_VOTE;
                    end
                end
                mgr_pkg::ST_VOTE, mgr_pkg::ST_UPDATE: begin
                    r_rd_vld <= w_rd_en;
                    r_rd_row <= w_rd_row;
                    if (w_rd_en) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if ((r_state == mgr_pkg::ST_VOTE) && r_rd_vld) begin
                        if (w_vote) begin
                            r_ones <= r_ones + CW'(1);
                        end else begin
                            r_zeros <= r_zeros + CW'(1);
                        end
                    end
                    // pass over once every row is issued and the last read is used
                    if (!w_rd_en && !r_rd_vld) begin
                        r_idx   <= '0;
                        r_state <= (r_state == mgr_pkg::ST_VOTE) ? mgr_pkg::ST_UPDATE
                                                                  : mgr_pkg::ST_DONE;
                    end
                end
                mgr_pkg::ST_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_hist      <= w_new_hist;
                        r_state     <= mgr_pkg::ST_IDLE;
                    end
                end
                default: r_state <= mgr_pkg::ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == mgr_pkg::ST_DONE) && (!r_out_valid || i_m_axis_tready)) begin
            r_out_ones  <= r_ones;
            r_out_min   <= w_min;
            r_out_small <= w_small;
            r_out_hist  <= w_new_hist;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_hist, r_out_small, r_out_min, r_out_ones};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `include "assert_macros.svh"

    `MGR_ASSERT_IMPL(a_no_rw_overlap, w_sc_we && w_rd_en, r_rd_row != w_rd_row, "row clash")
    `MGR_ASSERT_IMPL(a_votes_bounded, r_state != mgr_pkg::ST_IDLE, w_votes <= {1'b0, w_n}, "excess votes")
    `MGR_ASSERT_IMPL(a_all_voted, w_done, w_votes == {1'b0, w_n}, "round finished with missing votes")
    `MGR_ASSERT_IMPL(a_result_from_done, $rose(r_out_valid), $past(w_done), "stray result")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for minority_game_round. A predictor inside a small
// scoreboard class tracks strategies, scores, history and the two config
// registers, and expects one outcome per round transfer. Stimulus is a short
// directed opening, then a series of config settings, each with random
// loads, clears, unused commands and rounds.
// ----------------------------------------------------------------------------
module tb_top;
    import mgr_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 10;
    // covers any round still in flight
    localparam int DRAIN_CYCLES = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PATTERNS     = 1 << MAX_MEMORY;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 70;
    localparam int PHASE_ROUNDS = 4;

    // config per phase, phase 0 in the low bits: includes zero players, the
    // player saturation and memory lengths below 2 and above MAX_MEMORY
    localparam logic [NUM_PHASES*8-1:0] PHASE_PCNT =
        {8'd20, 8'd12, 8'd3, 8'd7, 8'd1, 8'd255, 8'd128, 8'd0};
    localparam logic [NUM_PHASES*4-1:0] PHASE_MLEN =
        {4'd9, 4'd5, 4'd0, 4'd15, 4'd8, 4'd1, 4'd2, 4'd3};

    // input transfer payload, highest field first in tdata
    typedef struct packed {
        logic       strategy_bit;
        logic [7:0] history_index;
        logic       which_strategy;
        logic [6:0] player;
    } t_load;

    // outcome of one round, highest field first in tdata
    typedef struct packed {
        logic [7:0] new_history;
        logic [7:0] minority_size;
        logic       minority_side;
        logic [7:0] ones_count;
    } t_outcome;

    // ------------------------------------------------------------------------
    // Scoreboard: game predictor plus the queue of outcomes not yet seen
    // ------------------------------------------------------------------------
    class game_scoreboard;
        bit [1:0]            strat   [MAX_PLAYERS][PATTERNS];
        bit [1:0]            written [MAX_PLAYERS][PATTERNS];
        bit [SCORE_W-1:0]    score   [MAX_PLAYERS][2];
        bit [MAX_MEMORY-1:0] history;
        bit [PCNT_W-1:0]     player_count;
        bit [MLEN_W-1:0]     memory_length;
        t_outcome            outcome_q[$];
        int                  errors;
        int                  outcomes_seen;

        function new();
            history       = HIST_RESET;
            player_count  = PCNT_RESET;
            memory_length = MLEN_RESET;
            errors        = 0;
            outcomes_seen = 0;
        endfunction

        function int active_players();
            return (player_count > MAX_PLAYERS) ? MAX_PLAYERS : int'(player_count);
        endfunction

        function int memory_depth();
            if (memory_length < MLEN_MIN)
                return int'(MLEN_MIN);
            if (memory_length > MLEN_MAX)
                return int'(MLEN_MAX);
            return int'(memory_length);
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void write_reg(t_reg idx, logic [CFG_W-1:0] value);
            if (idx == REG_PLAYER_COUNT)
                player_count = value;
            else
                memory_length = value[MLEN_W-1:0];
        endfunction

        function void note_input(t_cmd cmd, t_load ld);
            int                  n;
            int                  m;
            int                  p;
            int                  s;
            int                  ones;
            int                  zeros;
            bit                  side;
            bit [1:0]            e;
            bit [MAX_MEMORY-1:0] h;
            bit [MAX_MEMORY:0]   sum;
            t_outcome            res;
            case (cmd)
                CMD_LOAD: begin
                    strat[ld.player][ld.history_index][ld.which_strategy] = ld.strategy_bit;
                    written[ld.player][ld.history_index][ld.which_strategy] = 1'b1;
                end
                CMD_CLEAR: begin
                    for (p = 0; p < MAX_PLAYERS; p++) begin
                        score[p][0] = '0;
                        score[p][1] = '0;
                    end
                end
                CMD_ROUND: begin
                    n     = active_players();
                    m     = memory_depth();
                    h     = history;
                    ones  = 0;
                    zeros = 0;
                    // vote: strategy 0 wins ties on score
                    for (p = 0; p < n; p++) begin
                        e = strat[p][h];
                        if (e[(score[p][0] >= score[p][1]) ? 0 : 1])
                            ones++;
                        else
                            zeros++;
                    end
                    side = (zeros >= ones);
                    // every strategy that called the minority scores, saturating
                    for (p = 0; p < n; p++) begin
                        e = strat[p][h];
                        for (s = 0; s < 2; s++) begin
                            if (e[s] == side && score[p][s] != '1)
                                score[p][s]++;
                        end
                    end
                    // a sum, not an or: carries when m was lowered under old bits
                    sum = {1'b0, h >> 1} + ((MAX_MEMORY + 1)'(side) << (m - 1));
                    history = sum[MAX_MEMORY-1:0];
                    res.ones_count    = 8'(ones);
                    res.minority_side = side;
                    res.minority_size = side ? 8'(ones) : 8'(zeros);
                    res.new_history   = history;
                    outcome_q = {outcome_q, res};
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("ERROR: outcome %0d: %s", outcomes_seen, msg);
            errors++;
        endtask

        task compare(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(logic [31:0] data);
            t_outcome got;
            t_outcome want;
            got = data[$bits(t_outcome)-1:0];
            outcomes_seen++;
            if (outcome_q.size() == 0) begin
                report($sformatf("unexpected transfer, data %h", data));
            end else begin
                want = outcome_q.pop_front();
                compare("ones_count", got.ones_count, want.ones_count);
                compare("minority_side", got.minority_side, want.minority_side);
                compare("minority_size", got.minority_size, want.minority_size);
                compare("new_history", got.new_history, want.new_history);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and bench signals
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // [6:0] player, [7] which_strategy, [15:8] history_index,
    // [16] strategy_bit, [23:17] zero
    logic [23:0] i_s_axis_tdata;
    // [1:0] cmd
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [7:0] ones_count, [8] minority_side, [16:9] minority_size,
    // [24:17] new_history, [31:25] zero
    logic [31:0] o_m_axis_tdata;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [7:0]  i_cfg_wdata;

    game_scoreboard sb;
    int             send_idle_pct;   // chance per cycle the sender holds off
    int             recv_stall_pct;  // chance per cycle the receiver stalls
    int             sent_items;      // transfers the block acts on
    int             rounds_played;
    int             quiet_cycles;

    minority_game_round u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result side: every outcome transfer goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
    end

    // watchdog: too long without any transfer on either side means a hang
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One input transfer. tvalid stays high on return so back-to-back items
    // need no extra edge; whoever comes next lowers it if it has to.
    task automatic send_item(t_cmd cmd, t_load ld);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {7'b0, ld};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(cmd, ld);
        if (cmd != CMD_NONE)
            sent_items++;
    endtask

    task automatic send_load(int p, int s, int h, int b);
        t_load ld;
        ld.player         = 7'(p);
        ld.which_strategy = 1'(s);
        ld.history_index  = 8'(h);
        ld.strategy_bit   = 1'(b);
        send_item(CMD_LOAD, ld);
    endtask

    // A round reads both strategy bits of every active player at the current
    // history; any that were never loaded get a random bit first.
    task automatic play_round();
        int    n;
        int    p;
        int    s;
        t_load ld;
        n = sb.active_players();
        for (p = 0; p < n; p++) begin
            for (s = 0; s < 2; s++) begin
                if (!sb.written[p][sb.history][s])
                    send_load(p, s, sb.history, $urandom_range(1));
            end
        end
        ld = $bits(t_load)'($urandom);
        send_item(CMD_ROUND, ld);
        rounds_played++;
    endtask

    // Drop tvalid, collect every outstanding outcome, then wait out any load
    // or clear still inside the block.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] pcnt, logic [3:0] mlen);
        logic [7:0] mlen_word;
        // upper nibble is outside the register; random junk there
        mlen_word = {4'($urandom), mlen};
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_PLAYER_COUNT;
        i_cfg_wdata <= pcnt;
        @(posedge i_clk);
        sb.write_reg(REG_PLAYER_COUNT, pcnt);
        i_cfg_addr  <= REG_MEMORY_LENGTH;
        i_cfg_wdata <= mlen_word;
        @(posedge i_clk);
        sb.write_reg(REG_MEMORY_LENGTH, mlen_word);
        i_cfg_we    <= 1'b0;
    endtask

    // Random traffic for one config setting. Loads lean toward the players
    // and the pattern the next round will read, so rounds see fresh tables.
    task automatic run_phase();
        int    first_item;
        int    first_round;
        int    pick;
        int    n;
        t_load ld;
        first_item  = sent_items;
        first_round = rounds_played;
        while (sent_items - first_item < PHASE_ITEMS ||
               rounds_played - first_round < PHASE_ROUNDS) begin
            pick = $urandom_range(99);
            ld   = $bits(t_load)'($urandom);
            if (pick < 18) begin
                play_round();
            end else if (pick < 23) begin
                send_item(CMD_CLEAR, ld);
            end else if (pick < 28) begin
                send_item(CMD_NONE, ld);
            end else begin
                if ($urandom_range(1)) begin
                    n = sb.active_players();
                    ld.player        = 7'((n > 0) ? $urandom_range(n - 1) : $urandom);
                    ld.history_index = sb.history;
                end
                send_item(CMD_LOAD, ld);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_NONE;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = REG_PLAYER_COUNT;
        i_cfg_wdata     = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        sent_items      = 0;
        rounds_played   = 0;
        quiet_cycles    = 0;
        sb              = new();

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, on reset config (101 players, memory 2, history 2):
        // corner loads, the unused command, clears with and without scores
        send_load(0, 0, 0, 1);
        send_load(0, 1, 0, 0);
        send_load(MAX_PLAYERS - 1, 1, PATTERNS - 1, 1);
        send_load(MAX_PLAYERS - 1, 0, PATTERNS - 1, 0);
        send_item(CMD_NONE, '1);
        send_item(CMD_CLEAR, '0);
        play_round();
        play_round();
        send_item(CMD_CLEAR, '1);
        play_round();

        // random phases; idling mode rotates none / sender / receiver / both
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            write_regs(PHASE_PCNT[phase*8 +: 8], PHASE_MLEN[phase*4 +: 4]);
            case ((phase + 1) % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default: begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            run_phase();
        end

        settle();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
